// ===== hdl/aes128_pkg.sv =====
// AES-128 package: payload types, S-box tables and round helper functions.
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        mode;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  // Forward S-box table.
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse S-box table.
  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte j of the state is bits [127-8j -: 8].
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int j = 0; j < 16; j++) begin
      o[127-8*j -: 8] = inv ? INV_SBOX[s[127-8*j -: 8]] : SBOX[s[127-8*j -: 8]];
    end
    sub_bytes = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
        end else begin
          o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
        end
      end
    end
    shift_rows = o;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] a, input logic inv);
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, u, v;
    a0 = a[31:24]; a1 = a[23:16]; a2 = a[15:8]; a3 = a[7:0];
    // Inverse: premultiply by {05 00 04 00} then apply forward matrix.
    u = xt(xt(a0 ^ a2));
    v = xt(xt(a1 ^ a3));
    if (inv) begin
      a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
    end
    b0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
    b1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
    b2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
    b3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    mix_col = {b0, b1, b2, b3};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    end
    mix_columns = o;
  endfunction

endpackage

// ===== hdl/aes128_block_cipher_top.sv =====
// AES-128 ECB top level: key registers, key expansion and the round pipeline.
`timescale 1ns / 1ps
// Usage:
//   Configuration: write key_high (index 0) and key_low (index 1) through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i. Round keys are rebuilt by a 10-stage
//   expansion chain; busy stays high after each key write until every
//   round key holds the new key.
//   Input channel: a transaction is taken when start is high and busy is
//   low. Outside the key rebuild a new block enters every cycle.
//   Output channel: result_valid_o strobes for one cycle with result_o.
//   The receiver cannot stall; nothing is held back.
// Path from accept to strobe: input register (initial key add merged into
// it), ten round stages, output register. Throughput: one block per cycle,
// outside the key rebuild, set by the unrolled round pipeline (one round per stage).
// Reset: clears valid bits, the busy counter and the key registers to zero;
// the round-key registers reset to the expansion of the all-zero key.
module aes128_block_cipher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  aes128_pkg::aes_in_t           data_i,
  output logic                          result_valid_o,
  output aes128_pkg::aes_out_t          result_o,
  input  logic                          cfg_we_i,
  input  logic [aes128_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aes128_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import aes128_pkg::*;

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] rkey [NumRounds+1];
  logic [127:0] st   [NumRounds+1];
  logic         vld  [NumRounds+1];
  logic         dec  [NumRounds+1];
  logic         out_valid_q;
  aes_out_t     out_q;
  logic [3:0]   settle_q, settle_d;

  // Key rebuild counter: reloaded on every write, counts the expansion chain out.
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = 4'(NumRounds + 1);
    end else if (settle_q != 4'd0) begin
      settle_d = settle_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 4'd0;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign busy = (settle_q != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: key_hi_q <= cfg_wdata_i;
        REG_KEY_LOW:  key_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  aes128_key_sched u_ksched (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i ({key_hi_q, key_lo_q}),
    .rkey_o(rkey)
  );

  // Entry stage: initial whitening key (round 0 for encrypt, round 10 for decrypt).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dec[0] <= data_i.mode;
    st[0]  <= {data_i.data_high, data_i.data_low} ^
              (data_i.mode ? rkey[NumRounds] : rkey[0]);
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes128_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[r-1]),
      .dec_i  (dec[r-1]),
      .last_i (r == NumRounds),
      .state_i(st[r-1]),
      .rkey_i (dec[r-1] ? rkey[NumRounds-r] : rkey[r]),
      .valid_o(vld[r]),
      .dec_o  (dec[r]),
      .state_o(st[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= vld[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= st[NumRounds];
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;
endmodule

// ===== hdl/aes128_key_sched.sv =====
// AES-128 key expansion: 11 registered round keys recomputed on each key write.
`timescale 1ns / 1ps
module aes128_key_sched (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [127:0]  key_i,
  output logic [127:0]  rkey_o [aes128_pkg::NumRounds+1]
);
  import aes128_pkg::*;

  // One round of expansion per register stage; all keys settle once a key
  // register change has passed from rk_q[0] through rk_q[10].
  logic [127:0] rk_q [NumRounds+1];
  logic [127:0] rk_d [NumRounds+1];
  logic [7:0]   rcon [NumRounds];

  always_comb begin
    rcon[0] = 8'h01;
    for (int r = 1; r < NumRounds; r++) begin
      rcon[r] = xt(rcon[r-1]);
    end
    rk_d[0] = key_i;
    for (int r = 1; r <= NumRounds; r++) begin
      logic [31:0] t, w0, w1, w2, w3;
      t  = sub_word({rk_q[r-1][23:0], rk_q[r-1][31:24]}) ^ {rcon[r-1], 24'h0};
      w0 = rk_q[r-1][127:96] ^ t;
      w1 = rk_q[r-1][95:64] ^ w0;
      w2 = rk_q[r-1][63:32] ^ w1;
      w3 = rk_q[r-1][31:0] ^ w2;
      rk_d[r] = {w0, w1, w2, w3};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q[0] <= '0;
      rk_q[1] <= 128'h62636363626363636263636362636363;
      rk_q[2] <= 128'h9b9898c9f9fbfbaa9b9898c9f9fbfbaa;
      rk_q[3] <= 128'h90973450696ccffaf2f457330b0fac99;
      rk_q[4] <= 128'hee06da7b876a1581759e42b27e91ee2b;
      rk_q[5] <= 128'h7f2e2b88f8443e098dda7cbbf34b9290;
      rk_q[6] <= 128'hec614b851425758c99ff09376ab49ba7;
      rk_q[7] <= 128'h217517873550620bacaf6b3cc61bf09b;
      rk_q[8] <= 128'h0ef903333ba9613897060a04511dfa9f;
      rk_q[9] <= 128'hb1d4d8e28a7db9da1d7bb3de4c664941;
      rk_q[10] <= 128'hb4ef5bcb3e92e21123e951cf6f8f188e;
    end else begin
      for (int r = 0; r <= NumRounds; r++) begin
        rk_q[r] <= rk_d[r];
      end
    end
  end

  assign rkey_o = rk_q;
endmodule

// ===== hdl/aes128_round.sv =====
// One AES round stage, encrypt or decrypt, with its pipeline register.
`timescale 1ns / 1ps
module aes128_round (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic         dec_i,
  input  logic         last_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  output logic         valid_o,
  output logic         dec_o,
  output logic [127:0] state_o
);
  import aes128_pkg::*;

  logic [127:0] st_d, st_q, t;
  logic         valid_q, dec_q;

  always_comb begin
    if (!dec_i) begin
      t = shift_rows(sub_bytes(state_i, 1'b0), 1'b0);
      if (!last_i) t = mix_columns(t, 1'b0);
      st_d = t ^ rkey_i;
    end else begin
      t = sub_bytes(shift_rows(state_i, 1'b1), 1'b1) ^ rkey_i;
      st_d = last_i ? t : mix_columns(t, 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    dec_q <= dec_i;
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
  assign state_o = st_q;
endmodule

// ===== hdl/aes128_checker.sv =====
// Port-level checker for the AES-128 block and its bind.
`timescale 1ns / 1ps
module aes128_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic cfg_we_i
);
  import aes128_pkg::*;

  // Every accepted transaction yields a strobe after the entry, round and output registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##12 result_valid_o) else $error("missing result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 12)) else $error("spurious result");

  // A key write holds off new transactions while the round keys rebuild.
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy) else $error("not busy after key write");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid_o || !rst_ni) else $error("strobe after reset");
endmodule

bind aes128_block_cipher_top aes128_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .cfg_we_i      (cfg_we_i)
);
